@@ design/mact_pkg.sv @@
// shared types, constants and register indexes of the moving average crossover trader
package mact_pkg;

  localparam int unsigned HistoryDepthDef = 256;

  localparam int unsigned LenW    = 9;
  localparam int unsigned PriceW  = 32;
  localparam int unsigned SharesW = 32;
  localparam int unsigned CashW   = 48;
  localparam int unsigned SumW    = 40;
  localparam int unsigned CfgAddrW = 2;

  // reset values of the configuration registers
  localparam logic [LenW-1:0]  ShortLenRst = 9'd50;
  localparam logic [LenW-1:0]  LongLenRst  = 9'd200;
  localparam logic [CashW-1:0] InitBalRst  = 48'd655360000;

  // register indexes
  localparam logic [CfgAddrW-1:0] CfgShortLen = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgLongLen  = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgInitBal  = 2'd2;

  typedef enum logic [1:0] {
    ActNone  = 2'd0,
    ActBuy   = 2'd1,
    ActSell  = 2'd2,
    ActClose = 2'd3
  } action_e;

  typedef struct packed {
    logic [PriceW-1:0] close_price;
    logic              end_of_data;
  } in_item_t;

  typedef struct packed {
    action_e            action;
    logic [SharesW-1:0] shares;
    logic [CashW-1:0]   balance;
    logic               position_open;
  } out_item_t;

endpackage

@@ design/moving_average_crossover_trader.sv @@
// moving average crossover trader: windowed sums, crossover decision and cash bookkeeping
// steps: two history reads, window update, cross-multiply, decision; a sell or final close adds
//   product and apply, a buy adds the 48-step divider, buy, product and apply
// throughput: one item at a time; the next item is taken once the
//   result sits in the output register, so a waiting result does not hold it up
// reset: registers to 50 / 200 / 655360000, run state clear, cash at reset balance, history kept
module moving_average_crossover_trader #(
  parameter int unsigned HISTORY_DEPTH = mact_pkg::HistoryDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [mact_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [mact_pkg::CashW-1:0]        cfg_wdata_i,
  // bar input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mact_pkg::in_item_t                in_item_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mact_pkg::out_item_t               out_item_o
);
  import mact_pkg::*;

  // history address width and the largest usable window length
  localparam int unsigned AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned LenTop = (HISTORY_DEPTH < 256) ? HISTORY_DEPTH : 256;
  localparam int unsigned IW     = ((AW > LenW) ? AW : LenW) + 1;
  localparam int unsigned ProdW  = SharesW + PriceW;
  localparam int unsigned CmpW   = SumW + LenW;
  localparam int unsigned DivCntW = $clog2(CashW);

  localparam logic [LenW-1:0]    LenTopV = LenW'(LenTop);
  localparam logic [AW-1:0]      WpLast  = AW'(HISTORY_DEPTH - 1);
  localparam logic [IW-1:0]      DepthV  = IW'(HISTORY_DEPTH);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(CashW - 1);
  localparam logic [LenW-1:0]    BarMax  = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_S,
    ST_RD_L,
    ST_UPD,
    ST_MUL,
    ST_DEC,
    ST_DIV,
    ST_BUY,
    ST_PROD,
    ST_APPLY,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    OpBuy,
    OpSell,
    OpClose
  } op_e;

  // a length of zero acts as one, anything above the history size is clipped
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] v);
    if (v == '0) begin
      return LenW'(1);
    end else if (v > LenTopV) begin
      return LenTopV;
    end else begin
      return v;
    end
  endfunction

  // slot of the price that leaves a window of length len
  function automatic logic [AW-1:0] hist_idx(input logic [AW-1:0] wp,
                                             input logic [LenW-1:0] len);
    logic [IW-1:0] d;
    d = IW'(wp) - IW'(len);
    if (d[IW-1]) begin
      d = d + DepthV;
    end
    return d[AW-1:0];
  endfunction

  // configuration registers
  logic [LenW-1:0]  short_len_q, long_len_q;
  logic [CashW-1:0] init_bal_q;

  // control and item registers
  state_e            st_q;
  op_e               op_q;
  action_e           act_q;
  logic [PriceW-1:0] price_q;
  logic              last_q;
  logic [LenW-1:0]   bar_idx_q;

  // run state
  logic [AW-1:0]      wp_q;
  logic [LenW-1:0]    sfill_q, lfill_q, bar_q;
  logic [SumW-1:0]    ssum_q, lsum_q;
  logic               svalid_q, lvalid_q;
  logic [CashW-1:0]   cash_q;
  logic [SharesW-1:0] shares_q;
  logic               holding_q;

  // datapath registers
  logic [CmpW-1:0]    lhs_q, rhs_q;
  logic [PriceW-1:0]  rem_q;
  logic [CashW-1:0]   quo_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [ProdW-1:0]   prod_q;

  // history memory
  logic [PriceW-1:0] hist_mem [HISTORY_DEPTH];
  logic [PriceW-1:0] rdata_q;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;

  // output register
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      out_load;

  // combinational helpers
  logic [LenW-1:0]    sl, ll;
  logic [SumW-1:0]    ssum_add, lsum_add;
  logic [LenW-1:0]    sfill_nx, lfill_nx;
  logic [PriceW:0]    rem_sh, rem_dif;
  logic               div_ge;
  logic [CashW:0]     sale_sum;
  logic [ProdW:0]     sale_wide;
  logic [CashW-1:0]   sale_cash;
  logic [SharesW-1:0] buy_shares;

  assign sl = eff_len(short_len_q);
  assign ll = eff_len(long_len_q);

  // running sums take the new price; the oldest price leaves once the window is full
  assign ssum_add = ssum_q + SumW'(price_q);
  assign lsum_add = lsum_q + SumW'(price_q);
  assign sfill_nx = (sfill_q < sl) ? sfill_q + LenW'(1) : sfill_q;
  assign lfill_nx = (lfill_q < ll) ? lfill_q + LenW'(1) : lfill_q;

  // short window slot is read first, long window slot next, then the new price is written
  assign rd_addr = (st_q == ST_RD_S) ? hist_idx(wp_q, sl) : hist_idx(wp_q, ll);
  assign mem_we  = (st_q == ST_UPD);

  // one restoring divide step per cycle, dividend bits shift out as quotient bits shift in
  assign rem_sh  = {rem_q, quo_q[CashW-1]};
  assign rem_dif = rem_sh - {1'b0, price_q};
  assign div_ge  = (rem_sh >= {1'b0, price_q});

  // share count saturates at 32 bits
  assign buy_shares = (|quo_q[CashW-1:SharesW]) ? '1 : quo_q[SharesW-1:0];

  // sale proceeds added to cash with saturation at 48 bits
  assign sale_wide = (ProdW + 1)'(cash_q) + (ProdW + 1)'(prod_q);
  assign sale_sum  = sale_wide[CashW:0];
  assign sale_cash = (|sale_wide[ProdW:CashW]) ? '1 : sale_sum[CashW-1:0];

  // result handed over at the end of a bar once the output register is free
  assign out_load = (st_q == ST_FIN) && !(last_q && holding_q) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // history memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wp_q] <= price_q;
    end
    rdata_q <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= ShortLenRst;
      long_len_q  <= LongLenRst;
      init_bal_q  <= InitBalRst;
      st_q        <= ST_IDLE;
      op_q        <= OpBuy;
      act_q       <= ActNone;
      price_q     <= '0;
      last_q      <= 1'b0;
      bar_idx_q   <= '0;
      wp_q        <= '0;
      sfill_q     <= '0;
      lfill_q     <= '0;
      bar_q       <= '0;
      ssum_q      <= '0;
      lsum_q      <= '0;
      svalid_q    <= 1'b0;
      lvalid_q    <= 1'b0;
      cash_q      <= InitBalRst;
      shares_q    <= '0;
      holding_q   <= 1'b0;
      lhs_q       <= '0;
      rhs_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      div_cnt_q   <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      // configuration writes; the user must write only while the block is idle, the block does not enforce it
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgShortLen: short_len_q <= cfg_wdata_i[LenW-1:0];
          CfgLongLen:  long_len_q  <= cfg_wdata_i[LenW-1:0];
          CfgInitBal:  init_bal_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      // result register loaded at the end of a bar, cleared once taken downstream
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            price_q   <= in_item_i.close_price;
            last_q    <= in_item_i.end_of_data;
            bar_idx_q <= bar_q;
            act_q     <= ActNone;
            st_q      <= ST_RD_S;
          end
        end
        // short window slot read in flight
        ST_RD_S: begin
          st_q <= ST_RD_L;
        end
        // old short price arrives, long window slot read in flight
        ST_RD_L: begin
          ssum_q   <= (sfill_q < sl) ? ssum_add : ssum_add - SumW'(rdata_q);
          sfill_q  <= sfill_nx;
          svalid_q <= (sfill_nx >= sl);
          st_q     <= ST_UPD;
        end
        // old long price arrives, new price goes into the history
        ST_UPD: begin
          lsum_q   <= (lfill_q < ll) ? lsum_add : lsum_add - SumW'(rdata_q);
          lfill_q  <= lfill_nx;
          lvalid_q <= (lfill_nx >= ll);
          wp_q     <= (wp_q == WpLast) ? '0 : wp_q + AW'(1);
          if (bar_q != BarMax) begin
            bar_q <= bar_q + LenW'(1);
          end
          st_q <= ST_MUL;
        end
        // cross-multiply: short_sum / sl vs long_sum / ll without a divide
        ST_MUL: begin
          lhs_q <= svalid_q ? CmpW'(ssum_q) * CmpW'(ll) : '0;
          rhs_q <= lvalid_q ? CmpW'(lsum_q) * CmpW'(sl) : '0;
          st_q  <= ST_DEC;
        end
        // crossover decision, only once the bar index reaches the long length;
        // never buy at price zero
        ST_DEC: begin
          if (bar_idx_q >= ll && lhs_q > rhs_q && !holding_q && price_q != '0) begin
            rem_q     <= '0;
            quo_q     <= cash_q;
            div_cnt_q <= '0;
            st_q      <= ST_DIV;
          end else if (bar_idx_q >= ll && lhs_q < rhs_q && holding_q) begin
            op_q <= OpSell;
            st_q <= ST_PROD;
          end else begin
            st_q <= ST_FIN;
          end
        end
        // cash / price, one quotient bit per cycle
        ST_DIV: begin
          rem_q     <= div_ge ? rem_dif[PriceW-1:0] : rem_sh[PriceW-1:0];
          quo_q     <= {quo_q[CashW-2:0], div_ge};
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivLast) begin
            st_q <= ST_BUY;
          end
        end
        // open the position, possibly with zero shares
        ST_BUY: begin
          shares_q  <= buy_shares;
          holding_q <= 1'b1;
          act_q     <= ActBuy;
          op_q      <= OpBuy;
          st_q      <= ST_PROD;
        end
        // shares times price, shared by buy cost, sale and final close
        ST_PROD: begin
          prod_q <= ProdW'(shares_q) * ProdW'(price_q);
          st_q   <= ST_APPLY;
        end
        ST_APPLY: begin
          if (op_q == OpBuy) begin
            // cost never exceeds cash, so the low bits carry the whole product
            cash_q <= cash_q - prod_q[CashW-1:0];
          end else begin
            cash_q    <= sale_cash;
            shares_q  <= '0;
            holding_q <= 1'b0;
            act_q     <= (op_q == OpClose) ? ActClose : ActSell;
          end
          st_q <= ST_FIN;
        end
        // final bar closes an open position, then the result is handed over
        ST_FIN: begin
          if (last_q && holding_q) begin
            op_q <= OpClose;
            st_q <= ST_PROD;
          end else if (!out_valid_q || out_ready_i) begin
            out_item_q.action          <= act_q;
            out_item_q.shares          <= shares_q;
            out_item_q.balance         <= cash_q;
            out_item_q.position_open   <= holding_q;
            // end of data: start a fresh run, history contents stay
            if (last_q) begin
              wp_q      <= '0;
              sfill_q   <= '0;
              lfill_q   <= '0;
              bar_q     <= '0;
              ssum_q    <= '0;
              lsum_q    <= '0;
              svalid_q  <= 1'b0;
              lvalid_q  <= 1'b0;
              cash_q    <= init_bal_q;
              shares_q  <= '0;
              holding_q <= 1'b0;
            end
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  // the divider only runs on a nonzero price
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (price_q != '0))
    else $error("divider running with zero price");

  // buy cost fits in the cash it is taken from
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_APPLY && op_q == OpBuy) |->
      (prod_q[ProdW-1:CashW] == '0 && prod_q[CashW-1:0] <= cash_q))
    else $error("buy cost exceeds cash");

  // a final close leaves no position and no shares
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.action == ActClose) |->
      (!out_item_o.position_open && out_item_o.shares == '0))
    else $error("final close reports an open position");

endmodule

@@ dv/moving_average_crossover_trader_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the moving average crossover trader with its own trade predictor
module moving_average_crossover_trader_test;
  import mact_pkg::*;

  // random phases stop starting once this many bars have gone in, directed ones included
  localparam int unsigned TotalBars  = 1650;
  // worst correct run is ~2000 bars, each with its busy time plus sender gaps and receiver stalls, well under this
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TailCycles = 64;
  localparam logic [CashW-1:0] CashTop = 48'hFFFF_FFFF_FFFF;
  localparam longint      PriceTop   = 64'h0000_0000_FFFF_FFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CashW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;

  moving_average_crossover_trader DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // trade predictor: own copy of the registers and of the run state
  // ---------------------------------------------------------------------------
  logic [LenW-1:0]   reg_short_len;
  logic [LenW-1:0]   reg_long_len;
  logic [CashW-1:0]  reg_start_cash;

  logic [PriceW-1:0] hist_mem [HistoryDepthDef];
  int unsigned       hist_wr_ptr;
  int unsigned       short_cnt, long_cnt, bar_idx;
  logic [SumW-1:0]   short_win_sum, long_win_sum;
  logic [CashW-1:0]  cash_bal;
  logic [SharesW-1:0] held_qty;
  logic              in_position;

  // expected trade reports, oldest first
  out_item_t         pending_trades [$];

  int unsigned       bars_sent, reports_checked, fail_cnt, cfg_phases;
  int unsigned       action_seen [4];
  int unsigned       idle_pct, stall_pct;
  int unsigned       cycle_cnt;

  // a length of zero acts as one, anything past the history span acts as the span
  function automatic int unsigned window_span(input logic [LenW-1:0] len);
    int unsigned top;
    top = (HistoryDepthDef < 256) ? HistoryDepthDef : 256;
    if (len == 0) return 1;
    if (len > top) return top;
    return len;
  endfunction

  function automatic void restart_run();
    hist_wr_ptr   = 0;
    short_cnt     = 0;
    long_cnt      = 0;
    bar_idx       = 0;
    short_win_sum = '0;
    long_win_sum  = '0;
    cash_bal      = reg_start_cash;
    held_qty      = '0;
    in_position   = 1'b0;
  endfunction

  // add the new price, drop the one leaving the window once the window is full
  function automatic void slide_window(inout logic [SumW-1:0] sum, inout int unsigned fill,
                                       input int unsigned len, input logic [PriceW-1:0] price);
    sum = sum + SumW'(price);
    if (fill < len) begin
      fill++;
    end else begin
      sum = sum - SumW'(hist_mem[(hist_wr_ptr + HistoryDepthDef - len) % HistoryDepthDef]);
    end
  endfunction

  // cash after selling the whole position at this price, saturating at 48 bits
  function automatic logic [CashW-1:0] credit_sale(input logic [PriceW-1:0] price);
    logic [64:0] total;
    total = 65'(cash_bal) + 65'(64'(held_qty) * 64'(price));
    if (total > 65'(CashTop)) return CashTop;
    return total[CashW-1:0];
  endfunction

  function automatic out_item_t trade_bar(input logic [PriceW-1:0] price, input logic last);
    int unsigned sl, ll, bar_now;
    logic [63:0] lhs, rhs, quot;
    out_item_t   res;
    sl      = window_span(reg_short_len);
    ll      = window_span(reg_long_len);
    bar_now = bar_idx;
    res.action = ActNone;
    slide_window(short_win_sum, short_cnt, sl, price);
    slide_window(long_win_sum, long_cnt, ll, price);
    hist_mem[hist_wr_ptr] = price;
    hist_wr_ptr = (hist_wr_ptr + 1) % HistoryDepthDef;
    if (bar_idx < 511) bar_idx++;
    if (bar_now >= ll) begin
      // averages compared by cross-multiplying, an unfilled window counts as zero
      lhs = (short_cnt >= sl) ? 64'(short_win_sum) * 64'(ll) : 64'd0;
      rhs = (long_cnt >= ll) ? 64'(long_win_sum) * 64'(sl) : 64'd0;
      if (lhs > rhs && !in_position) begin
        if (price != 0) begin
          quot = 64'(cash_bal) / 64'(price);
          if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
          held_qty    = quot[SharesW-1:0];
          cash_bal    = cash_bal - CashW'(quot * 64'(price));
          in_position = 1'b1;
          res.action  = ActBuy;
        end
      end else if (lhs < rhs && in_position) begin
        cash_bal    = credit_sale(price);
        held_qty    = '0;
        in_position = 1'b0;
        res.action  = ActSell;
      end
    end
    if (last && in_position) begin
      cash_bal    = credit_sale(price);
      held_qty    = '0;
      in_position = 1'b0;
      res.action  = ActClose;
    end
    res.shares        = held_qty;
    res.balance       = cash_bal;
    res.position_open = in_position;
    if (last) restart_run();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker and receiver stalls
  // ---------------------------------------------------------------------------
  out_item_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      reports_checked++;
      action_seen[out_item_o.action]++;
      if (pending_trades.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result, action %0d shares %0d balance %h", $time,
                 out_item_o.action, out_item_o.shares, out_item_o.balance);
      end else begin
        want = pending_trades.pop_front();
        // only the first hundred mismatches are printed, all are counted
        if (want.action != out_item_o.action) begin
          fail_cnt++;
          if (fail_cnt <= 100)
            $display("%0t: action expected %0d actual %0d", $time, want.action,
                     out_item_o.action);
        end
        if (want.shares != out_item_o.shares) begin
          fail_cnt++;
          if (fail_cnt <= 100)
            $display("%0t: shares expected %0d actual %0d", $time, want.shares,
                     out_item_o.shares);
        end
        if (want.balance != out_item_o.balance) begin
          fail_cnt++;
          if (fail_cnt <= 100)
            $display("%0t: balance expected %h actual %h", $time, want.balance,
                     out_item_o.balance);
        end
        if (want.position_open != out_item_o.position_open) begin
          fail_cnt++;
          if (fail_cnt <= 100)
            $display("%0t: position_open expected %0d actual %0d", $time,
                     want.position_open, out_item_o.position_open);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("moving_average_crossover_trader verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shared driving tasks
  // ---------------------------------------------------------------------------
  task automatic set_idling(input int unsigned sender, input int unsigned receiver);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  // one bar into the block; valid stays up when the next bar follows without a gap
  task automatic send_bar(input logic [PriceW-1:0] price, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i              <= 1'b1;
    in_item_i.close_price   <= price;
    in_item_i.end_of_data   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    pending_trades.insert(pending_trades.size(), trade_bar(price, last));
    bars_sent++;
  endtask

  // sender holds off until every expected report is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_trades.size() != 0);
  endtask

  // registers only change with the block idle
  task automatic write_config(input logic [LenW-1:0] short_len, input logic [LenW-1:0] long_len,
                              input logic [CashW-1:0] start_cash);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgShortLen;
    cfg_wdata_i <= CashW'(short_len);
    @(posedge clk_i);
    reg_short_len = short_len;
    cfg_addr_i  <= CfgLongLen;
    cfg_wdata_i <= CashW'(long_len);
    @(posedge clk_i);
    reg_long_len = long_len;
    cfg_addr_i  <= CfgInitBal;
    cfg_wdata_i <= start_cash;
    @(posedge clk_i);
    reg_start_cash = start_cash;
    cfg_we_i <= 1'b0;
    cfg_phases++;
  endtask

  // random-walk prices with trend flips so the averages keep crossing, plus some noise
  task automatic run_trend(input int unsigned nbars, input bit end_run, input bit pause_mid);
    longint            level, step_max, delta;
    bit                rising;
    int unsigned       pick;
    logic [PriceW-1:0] price;
    logic              last;
    case ($urandom_range(3))
      0:       level = longint'($urandom_range(1, 500)) << 16;
      1:       level = longint'($urandom);
      2:       level = longint'($urandom_range(0, 255));
      default: level = longint'($urandom_range(1, 50)) << 16;
    endcase
    rising = $urandom_range(1);
    for (int unsigned i = 0; i < nbars; i++) begin
      if (pause_mid && i == nbars / 2) wait_drained();
      if ($urandom_range(3) == 0) rising = !rising;
      step_max = level / 16 + 2;
      delta    = longint'($urandom_range(0, 32'(step_max)));
      level    = rising ? level + delta : level - delta;
      if (level < 0) level = 0;
      if (level > PriceTop) level = PriceTop;
      price = level[PriceW-1:0];
      last  = end_run && (i == nbars - 1);
      pick  = $urandom_range(99);
      // stray prices: full random, zero and top of range
      if (pick < 4) begin
        price = $urandom;
      end else if (pick < 6) begin
        price = '0;
      end else if (pick < 8) begin
        price = '1;
      end
      // now and then the run is cut short by an early last bar
      if ($urandom_range(99) < 2) last = 1'b1;
      send_bar(price, last);
    end
  endtask

  function automatic logic [LenW-1:0] pick_window(input bit any_width);
    int unsigned     r;
    logic [LenW-1:0] len;
    r = $urandom_range(99);
    if (r < 6) begin
      len = '0;
    end else if (any_width && r < 12) begin
      len = $urandom;
    end else if (r < 80) begin
      len = $urandom_range(1, 12);
    end else begin
      len = $urandom_range(13, 48);
    end
    return len;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // short 1 / long 2: a rising bar buys, a falling bar sells
  task automatic test_saturating_trades();
    set_idling(0, 0);
    write_config(1, 2, CashTop);
    send_bar(32'd3, 1'b0);
    send_bar(32'd3, 1'b0);
    send_bar(32'd0, 1'b0);            // falling with no position, nothing happens
    send_bar(32'd1, 1'b0);            // buy at the smallest price, share count saturates
    send_bar(32'hFFFF_FFFF, 1'b0);    // rising while holding
    send_bar(32'hFFFF_FFF0, 1'b0);    // sale large enough to saturate cash
    send_bar(32'hFFFF_FFFF, 1'b0);    // buy at the top price leaves 65535 in cash
    send_bar(32'd0, 1'b0);            // sale at price zero adds nothing
    send_bar(32'd0, 1'b0);
    send_bar(32'd5, 1'b0);            // buy with the cash left over opens a position
    send_bar(32'd7, 1'b1);            // last bar closes the open position
  endtask

  // short 2 / long 0 (acts as 1): a falling bar buys, no starting cash
  task automatic test_zero_price_and_cash();
    set_idling(48, 48);
    write_config(2, 0, '0);
    send_bar(32'd4, 1'b0);
    send_bar(32'd0, 1'b0);            // buy signal at price zero is ignored
    send_bar(32'd3, 1'b0);
    send_bar(32'd2, 1'b0);            // zero shares bought, position still opens
    send_bar(32'd9, 1'b0);
    send_bar(32'd8, 1'b1);            // last bar buys, then the close replaces it
    send_bar(32'd6, 1'b1);            // one-bar run, last bar with no position
  endtask

  // a 530-bar run aimed at saturating the bar counter past 511 (early last bars may restart it), one drain mid-run
  task automatic test_bar_count_saturation();
    set_idling(0, 48);
    write_config(3, 7, InitBalRst);
    run_trend(530, 1'b1, 1'b1);
  endtask

  // a full-depth long window, then lengths past the history span changed mid-run
  task automatic test_wide_windows();
    logic [CashW-1:0] start_cash;
    set_idling(13, 13);
    start_cash = CashW'({$urandom, $urandom});
    write_config(9, 256, start_cash);
    run_trend(280, 1'b0, 1'b0);
    write_config(511, 300, InitBalRst);
    run_trend(20, 1'b1, 1'b0);
  endtask

  // random phases: lengths and cash vary, runs sometimes continue across a config change
  task automatic test_random_crossovers();
    int unsigned      phase;
    logic [LenW-1:0]  short_len, long_len;
    logic [CashW-1:0] start_cash;
    phase = 0;
    while (bars_sent < TotalBars) begin
      case (phase % 4)
        0:       set_idling(0, 0);
        1:       set_idling(48, 0);
        2:       set_idling(0, 48);
        default: set_idling(13, 13);
      endcase
      short_len = pick_window(1'b1);
      long_len  = pick_window(1'b0);
      case ($urandom_range(3))
        0:       start_cash = CashW'({$urandom, $urandom});
        1:       start_cash = CashW'($urandom_range(1, 100000)) << 16;
        2:       start_cash = InitBalRst;
        default: start_cash = CashW'($urandom_range(0, 1000));
      endcase
      write_config(short_len, long_len, start_cash);
      run_trend(window_span(long_len) + $urandom_range(8, 50), $urandom_range(99) < 80,
                phase % 3 == 1);
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = CfgShortLen;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    cycle_cnt   = 0;
    bars_sent   = 0;
    reports_checked = 0;
    fail_cnt    = 0;
    cfg_phases  = 0;
    for (int i = 0; i < 4; i++) action_seen[i] = 0;
    for (int i = 0; i < HistoryDepthDef; i++) hist_mem[i] = '0;
    reg_short_len  = ShortLenRst;
    reg_long_len   = LongLenRst;
    reg_start_cash = InitBalRst;
    restart_run();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_saturating_trades();
    test_zero_price_and_cash();
    test_bar_count_saturation();
    test_wide_windows();
    test_random_crossovers();

    // drain, then give the block time to show any stray result
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d bars over %0d register settings, %0d results checked", bars_sent,
             cfg_phases, reports_checked);
    $display("trades seen: %0d buys, %0d sells, %0d closes on a last bar, %0d quiet bars",
             action_seen[ActBuy], action_seen[ActSell], action_seen[ActClose],
             action_seen[ActNone]);
    if (fail_cnt == 0 && pending_trades.size() == 0) begin
      $display("moving_average_crossover_trader verification clean");
    end else begin
      $display("moving_average_crossover_trader verification failed");
    end
    $finish;
  end

endmodule

@@ moving_average_crossover_trader.f @@
design/mact_pkg.sv
design/moving_average_crossover_trader.sv
dv/moving_average_crossover_trader_test.sv
